// ===== rtl/wsteer_pkg.sv =====
// ----------------------------------------------------------------------------
// wsteer_pkg
// Shared widths, constants and the arctangent table for waypoint steering.
// ----------------------------------------------------------------------------
package wsteer_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int STEP_W       = 5;
  localparam int VEC_W        = 32;
  localparam int ANG_W        = 21;
  localparam int DIFF_W       = 17;
  localparam int SQR_STEPS    = 16;

  localparam logic signed [ANG_W-1:0] PI_Q16       = 21'sd205887;
  localparam logic signed [17:0]      PI_Q12       = 18'sd12868;
  localparam logic signed [17:0]      COARSE_LIMIT = 18'sd6434;

  localparam logic [3:0] REG_TARGET_X  = 4'd0;
  localparam logic [3:0] REG_TARGET_Y  = 4'd1;
  localparam logic [3:0] REG_ORIGIN_X  = 4'd2;
  localparam logic [3:0] REG_ORIGIN_Y  = 4'd3;
  localparam logic [3:0] REG_DRIVE_SPD = 4'd4;
  localparam logic [3:0] REG_TURN_SPD  = 4'd5;
  localparam logic [3:0] REG_HEAD_TOL  = 4'd6;
  localparam logic [3:0] REG_ARRIVE_R  = 4'd7;

  function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30385;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/wsteer_sqr.sv =====
// ----------------------------------------------------------------------------
// wsteer_sqr
// Bit-serial squarer: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wsteer_sqr
  import wsteer_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [15:0] op,
  output logic [31:0] prod
);

  logic [15:0] mplier;
  logic [31:0] mcand;
  logic [31:0] acc;

  always_ff @(posedge clk) begin
    if (load) begin
      mplier <= op;
      mcand  <= {16'd0, op};
      acc    <= '0;
    end else begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mplier <= mplier >> 1;
      mcand  <= mcand << 1;
    end
  end

  assign prod = acc;

endmodule

// ===== rtl/wsteer_cordic.sv =====
// ----------------------------------------------------------------------------
// wsteer_cordic
// Iterative vectoring CORDIC, one rotation per cycle, angle in Q4.16.
// ----------------------------------------------------------------------------
module wsteer_cordic
  import wsteer_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  output logic signed [ANG_W-1:0]  angle,
  output logic                    done
);

  logic signed [VEC_W-1:0] x;
  logic signed [VEC_W-1:0] y;
  logic signed [ANG_W-1:0] z;
  logic [STEP_W-1:0]       step;
  logic signed [VEC_W-1:0] x0;
  logic signed [VEC_W-1:0] y0;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  logic signed [ANG_W-1:0] at;

  assign x0 = VEC_W'(dx) <<< 12;
  assign y0 = VEC_W'(dy) <<< 12;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = ANG_W'($signed({1'b0, atan_q16(step)}));
  assign done = (step == STEP_W'(CORDIC_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_W'(CORDIC_STEPS);
    end else if (load) begin
      step <= '0;
    end else if (!done) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (dx < 0) begin
        x <= -x0;
        y <= -y0;
        z <= (dy >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (!done) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
    end
  end

  assign angle = z;

endmodule

// ===== rtl/waypoint_heading_steering.sv =====
// ----------------------------------------------------------------------------
// waypoint_heading_steering
// Steers from the origin toward the target waypoint, one command per pose.
// ----------------------------------------------------------------------------
// Steps: the serial squarers, the arrival check, the CORDIC rotations, the angle round and
// the output register, from transfer in to result valid.
// A new pose is taken only in the idle state, once the last result is registered;
// a stalled result holds the block in its output state and adds its wait.
// An arrived pose skips the CORDIC and the angle round.
// Reset is synchronous: registers take their defaults, arrived latch clears.
module waypoint_heading_steering
  import wsteer_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [14:0] heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] linear_cmd,
  output logic signed [15:0] angular_cmd,
  output logic               arrived
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQR  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_ROT  = 6'b001000,
    ST_RND  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [3:0]  target_x, target_y, origin_x, origin_y;
  logic [14:0] drive_speed, turn_speed, arrive_radius;
  logic [13:0] heading_tolerance;
  logic        done_latch;

  logic signed [15:0]       px, py;
  logic signed [14:0]       h;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [DIFF_W-1:0] dx_in, dy_in;
  logic [15:0]              adx, ady;
  logic [4:0]               cnt;
  logic [31:0]              sqx, sqy, sqr;
  logic                     near;
  logic                     hit;
  logic signed [ANG_W-1:0]  z;
  logic                     cdone;
  logic signed [17:0]       a;
  logic signed [ANG_W-1:0]  zr;
  logic signed [17:0]       rq;
  logic                     take_in;
  logic                     out_free;

  logic signed [17:0] aa, ha, fine, coarse, dif, hx, gx, gy, pxx, pyy;
  logic               turn, same, wrap;
  logic signed [15:0] wp, wn, vp, vn, lin, ang;

  assign in_ready = (state == ST_IDLE);
  assign take_in  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign dx_in = $signed({5'd0, target_x, 8'd0}) - DIFF_W'(pos_x);
  assign dy_in = $signed({5'd0, target_y, 8'd0}) - DIFF_W'(pos_y);
  assign adx   = dx_in[DIFF_W-1] ? 16'(-dx_in) : dx_in[15:0];
  assign ady   = dy_in[DIFF_W-1] ? 16'(-dy_in) : dy_in[15:0];

  wsteer_sqr u_sqx (.clk(clk), .load(take_in), .op(adx), .prod(sqx));
  wsteer_sqr u_sqy (.clk(clk), .load(take_in), .op(ady), .prod(sqy));
  wsteer_sqr u_sqr (.clk(clk), .load(take_in), .op({1'b0, arrive_radius}), .prod(sqr));

  assign near = ({1'b0, sqx} + {1'b0, sqy}) <= {1'b0, sqr};
  assign hit  = done_latch || near;

  wsteer_cordic u_cordic (
    .clk(clk), .rst(rst), .load(state == ST_CHK && !hit),
    .dx(dx), .dy(dy), .angle(z), .done(cdone)
  );

  assign zr = (z + ANG_W'(8)) >>> 4;
  assign rq = 18'(zr);

  always_ff @(posedge clk) begin
    if (take_in) begin
      px <= pos_x;
      py <= pos_y;
      h  <= heading;
      dx <= dx_in;
      dy <= dy_in;
    end
    if (state == ST_RND) begin
      if (rq > PI_Q12) begin
        a <= PI_Q12;
      end else if (rq < -PI_Q12) begin
        a <= -PI_Q12;
      end else begin
        a <= rq;
      end
    end
  end

  always_comb begin
    hx     = 18'(h);
    aa     = (a < 0) ? -a : a;
    ha     = (hx < 0) ? -hx : hx;
    dif    = aa - ha;
    fine   = (dif < 0) ? -dif : dif;
    coarse = (a - hx < 0) ? hx - a : a - hx;
    turn   = (fine > $signed({4'd0, heading_tolerance})) || (coarse > COARSE_LIMIT);
    same   = (a < 0) == (hx < 0);
    wrap   = ((PI_Q12 - aa) + (PI_Q12 - ha)) < (aa + ha);
    wp     = $signed({1'b0, turn_speed});
    wn     = -wp;
    vp     = $signed({1'b0, drive_speed});
    vn     = -vp;
    gx     = $signed({6'd0, target_x, 8'd0});
    gy     = $signed({6'd0, target_y, 8'd0});
    pxx    = 18'(px);
    pyy    = 18'(py);
    lin    = '0;
    ang    = '0;
    if (turn) begin
      if (same) begin
        ang = (hx > a) ? wn : wp;
      end else if (wrap) begin
        ang = (hx > 0) ? wp : wn;
      end else begin
        ang = (hx > 0) ? wn : wp;
      end
    end else if (origin_x < target_x) begin
      lin = (pxx < gx) ? vp : vn;
    end else if (origin_x > target_x) begin
      lin = (pxx > gx) ? vp : vn;
    end else if (origin_y > target_y) begin
      lin = (pyy > gy) ? vp : vn;
    end else if (origin_y < target_y) begin
      lin = (pyy < gy) ? vp : vn;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (take_in) state_next = ST_SQR;
      ST_SQR:  if (cnt == 5'(SQR_STEPS - 1)) state_next = ST_CHK;
      ST_CHK:  state_next = hit ? ST_OUT : ST_ROT;
      ST_ROT:  if (cdone) state_next = ST_RND;
      ST_RND:  state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == ST_SQR) ? cnt + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x          <= '0;
      target_y          <= '0;
      origin_x          <= '0;
      origin_y          <= '0;
      drive_speed       <= 15'd51;
      turn_speed        <= 15'd819;
      heading_tolerance <= 14'd410;
      arrive_radius     <= 15'd26;
      done_latch        <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TARGET_X:  begin target_x <= cfg_data[3:0]; done_latch <= 1'b0; end
        REG_TARGET_Y:  begin target_y <= cfg_data[3:0]; done_latch <= 1'b0; end
        REG_ORIGIN_X:  begin origin_x <= cfg_data[3:0]; done_latch <= 1'b0; end
        REG_ORIGIN_Y:  begin origin_y <= cfg_data[3:0]; done_latch <= 1'b0; end
        REG_DRIVE_SPD: drive_speed <= cfg_data;
        REG_TURN_SPD:  turn_speed <= cfg_data;
        REG_HEAD_TOL:  heading_tolerance <= cfg_data[13:0];
        REG_ARRIVE_R:  arrive_radius <= cfg_data;
        default:       ;
      endcase
    end else if (state == ST_CHK && hit) begin
      done_latch <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      linear_cmd  <= done_latch ? 16'sd0 : lin;
      angular_cmd <= done_latch ? 16'sd0 : ang;
      arrived     <= done_latch;
    end
  end

  a_arrived_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> linear_cmd == 16'sd0 && angular_cmd == 16'sd0)
    else $error("arrived result carries a nonzero command");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> linear_cmd == 16'sd0 || angular_cmd == 16'sd0)
    else $error("drive and turn commands both nonzero");

  a_transfer_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SQR && cnt == 5'd0)
    else $error("transfer in did not start squaring");

  a_hit_latches: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHK && hit && !cfg_wr_en |=> done_latch && state == ST_OUT)
    else $error("arrival not latched");

endmodule
